// File: hdl/lru_writeback_block_cache_directory_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block cache directory
// Shared property shorthands, clocked on the rising edge, reset disabled.
// ----------------------------------------------------------------------------
`ifndef LRU_WRITEBACK_BLOCK_CACHE_DIRECTORY_MACROS_SVH
`define LRU_WRITEBACK_BLOCK_CACHE_DIRECTORY_MACROS_SVH

// Same-cycle implication
`define LWBCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define LWBCD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/lwbcd_pkg.sv
// ----------------------------------------------------------------------------
// lwbcd_pkg
// Types, codes and sizes shared by the block cache directory modules.
// ----------------------------------------------------------------------------
package lwbcd_pkg;

	// Number of cache slots
	localparam int ENTRIES    = 16;
	localparam int SLOT_W     = $clog2(ENTRIES);
	localparam int RANK_W     = $clog2(ENTRIES);
	localparam int SLOT_OUT_W = 6;
	localparam int BLK_W      = 32;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [RANK_W-1:0] rank_t;

	// Rank held by the least recently used slot of a full cache
	localparam rank_t RANK_LRU = rank_t'(ENTRIES - 1);

	// Request commands
	typedef enum logic [1:0] {
		CMD_REQ   = 2'd0,
		CMD_DIRTY = 2'd1,
		CMD_FLUSH = 2'd2
	} cmd_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_ANSWER = 2'd0,
		KIND_WB     = 2'd1,
		KIND_DONE   = 2'd2
	} kind_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_WB,
		ST_ANSWER,
		ST_FLUSH,
		ST_DONE
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic lookup;
		logic set_dirty;
		logic emit_wb;
		logic emit_answer;
		logic flush_start;
		logic flush_step;
		logic emit_flush_wb;
		logic emit_done;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       hit;
		logic       full;
		logic       victim_dirty;
		logic       flush_hit;
		logic       flush_last;
		logic       out_free;
	} dp_stat_t;

endpackage

// File: hdl/lwbcd_req_if.sv
// ----------------------------------------------------------------------------
// lwbcd_req_if
// Request channel: command, block number and read flag with valid/ready.
// ----------------------------------------------------------------------------
interface lwbcd_req_if
	import lwbcd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [1:0]       cmd;
	logic [BLK_W-1:0] block_no;
	logic             do_read;

	modport source (output valid, output cmd, output block_no, output do_read, input ready);
	modport sink   (input valid, input cmd, input block_no, input do_read, output ready);
endinterface

// File: hdl/lwbcd_rsp_if.sv
// ----------------------------------------------------------------------------
// lwbcd_rsp_if
// Result channel: answers, writeback orders and flush done with valid/ready.
// ----------------------------------------------------------------------------
interface lwbcd_rsp_if
	import lwbcd_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [1:0]            kind;
	logic [BLK_W-1:0]      block_addr;
	logic [SLOT_OUT_W-1:0] slot;
	logic                  hit;
	logic                  fill_needed;
	logic                  last;

	modport source (output valid, output kind, output block_addr, output slot,
		output hit, output fill_needed, output last, input ready);
	modport sink   (input valid, input kind, input block_addr, input slot,
		input hit, input fill_needed, input last, output ready);
endinterface

// File: hdl/lwbcd_ctrl.sv
// ----------------------------------------------------------------------------
// lwbcd_ctrl
// Sequencer: takes one request at a time, steps lookup, writeback, answer
// and the flush walk, and issues datapath commands.
// ----------------------------------------------------------------------------
module lwbcd_ctrl
	import lwbcd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t st,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (st.cmd == CMD_REQ) begin
					// full miss on a dirty victim writes it back first
					if (!st.hit && st.full && st.victim_dirty) begin
						state_nxt = ST_WB;
					end else begin
						state_nxt = ST_ANSWER;
					end
				end else if (st.cmd == CMD_DIRTY) begin
					cmd.set_dirty = st.hit;
					state_nxt     = ST_IDLE;
				end else if (st.cmd == CMD_FLUSH) begin
					cmd.flush_start = 1'b1;
					state_nxt       = ST_FLUSH;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_WB: begin
				if (st.out_free) begin
					cmd.emit_wb = 1'b1;
					state_nxt   = ST_ANSWER;
				end
			end
			ST_ANSWER: begin
				if (st.out_free) begin
					cmd.emit_answer = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				// one rank per cycle, stall only on a dirty slot that finds the result register occupied
				if (!st.flush_hit || st.out_free) begin
					cmd.emit_flush_wb = st.flush_hit;
					if (st.flush_last) begin
						state_nxt = ST_DONE;
					end else begin
						cmd.flush_step = 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.emit_done = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/lwbcd_dp.sv
// ----------------------------------------------------------------------------
// lwbcd_dp
// Directory datapath: tags, valid, dirty and recency ranks, parallel tag
// compare, victim select, flush rank walk and the result register.
// ----------------------------------------------------------------------------
module lwbcd_dp
	import lwbcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              st,
	input  logic [1:0]            in_cmd,
	input  logic [BLK_W-1:0]      in_block_no,
	input  logic                  in_do_read,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            out_kind,
	output logic [BLK_W-1:0]      out_block_addr,
	output logic [SLOT_OUT_W-1:0] out_slot,
	output logic                  out_hit,
	output logic                  out_fill_needed,
	output logic                  out_last
);

	// Directory state
	logic [BLK_W-1:0] tag_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] dirty_q;
	rank_t rank_q [ENTRIES];

	// Latched request
	logic [1:0]       cmd_q;
	logic [BLK_W-1:0] blk_q;
	logic             rd_q;

	// Lookup outcome
	slot_t lk_slot_q;
	logic  lk_hit_q;
	logic  lk_free_q;

	rank_t flush_rank_q;
	logic  rsp_valid_q;

	// Combinational lookup
	logic  match_any;
	slot_t hit_slot;
	logic  free_any;
	slot_t free_slot;
	slot_t victim;
	logic  fl_any;
	slot_t fl_slot;
	rank_t s_rank;
	slot_t rd_slot;
	logic  emit_any;

	always_comb begin
		match_any = 1'b0;
		hit_slot  = '0;
		free_any  = 1'b0;
		free_slot = '0;
		victim    = '0;
		fl_any    = 1'b0;
		fl_slot   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (valid_q[i] && tag_q[i] == blk_q) begin
				match_any = 1'b1;
				hit_slot  = slot_t'(i);
			end
			// highest free slot wins
			if (!valid_q[i]) begin
				free_any  = 1'b1;
				free_slot = slot_t'(i);
			end
			if (valid_q[i] && rank_q[i] == RANK_LRU) begin
				victim = slot_t'(i);
			end
			if (valid_q[i] && rank_q[i] == flush_rank_q) begin
				fl_any  = 1'b1;
				fl_slot = slot_t'(i);
			end
		end
	end

	assign s_rank   = rank_q[lk_slot_q];
	assign rd_slot  = cmd.emit_flush_wb ? fl_slot : lk_slot_q;
	assign emit_any = cmd.emit_wb | cmd.emit_answer | cmd.emit_flush_wb | cmd.emit_done;

	// Status to controller
	always_comb begin
		st.cmd          = cmd_q;
		st.hit          = match_any;
		st.full         = !free_any;
		st.victim_dirty = dirty_q[victim];
		st.flush_hit    = fl_any && dirty_q[fl_slot];
		st.flush_last   = (flush_rank_q == RANK_LRU);
		st.out_free     = !rsp_valid_q || out_ready;
	end

	// Valid, dirty, ranks, flush pointer and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			dirty_q      <= '0;
			flush_rank_q <= '0;
			rsp_valid_q  <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cmd.set_dirty) begin
				dirty_q[hit_slot] <= 1'b1;
			end
			if (cmd.emit_flush_wb) begin
				dirty_q[fl_slot] <= 1'b0;
			end
			// promote the answered slot to most recent
			if (cmd.emit_answer) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && slot_t'(i) != lk_slot_q &&
						(lk_free_q || rank_q[i] < s_rank)) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
				rank_q[lk_slot_q]  <= '0;
				valid_q[lk_slot_q] <= 1'b1;
				if (!lk_hit_q) begin
					dirty_q[lk_slot_q] <= 1'b0;
				end
			end
			if (cmd.flush_start) begin
				flush_rank_q <= '0;
			end else if (cmd.flush_step) begin
				flush_rank_q <= flush_rank_q + 1'b1;
			end
			if (emit_any) begin
				rsp_valid_q <= 1'b1;
			end else if (out_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Tags, request latch, lookup registers
	always_ff @(posedge clk) begin
		if (cmd.emit_answer && !lk_hit_q) begin
			tag_q[lk_slot_q] <= blk_q;
		end
		if (cmd.load) begin
			cmd_q <= in_cmd;
			blk_q <= in_block_no;
			rd_q  <= in_do_read;
		end
		if (cmd.lookup) begin
			lk_hit_q  <= match_any;
			lk_free_q <= !match_any && free_any;
			lk_slot_q <= match_any ? hit_slot : (free_any ? free_slot : victim);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.emit_wb || cmd.emit_flush_wb) begin
			out_kind        <= KIND_WB;
			out_block_addr  <= tag_q[rd_slot];
			out_slot        <= SLOT_OUT_W'(rd_slot);
			out_hit         <= 1'b0;
			out_fill_needed <= 1'b0;
			out_last        <= 1'b0;
		end else if (cmd.emit_answer) begin
			out_kind        <= KIND_ANSWER;
			out_block_addr  <= blk_q;
			out_slot        <= SLOT_OUT_W'(lk_slot_q);
			out_hit         <= lk_hit_q;
			out_fill_needed <= !lk_hit_q && rd_q;
			out_last        <= 1'b1;
		end else if (cmd.emit_done) begin
			out_kind        <= KIND_DONE;
			out_block_addr  <= '0;
			out_slot        <= '0;
			out_hit         <= 1'b0;
			out_fill_needed <= 1'b0;
			out_last        <= 1'b1;
		end
	end

	assign out_valid = rsp_valid_q;

endmodule

// File: hdl/lru_writeback_block_cache_directory.sv
// ----------------------------------------------------------------------------
// lru_writeback_block_cache_directory
// Fully associative LRU directory of a write-back block cache.
// ----------------------------------------------------------------------------
// Usage:
//   req carries cmd (request, mark dirty, flush), block_no and do_read on a
//   valid/ready handshake; rsp returns answers, writeback orders and a flush
//   done item, with last set on the final item of a request; mark dirty
//   and unused codes return no item. Requests are handled one at a time.
//   A lookup steps from accept through the lookup state to the answer
//   state, which loads the answer into the result register (through the
//   writeback state first when a dirty LRU victim is written back), and
//   the next request is taken in the idle state after that. Mark dirty
//   and unused codes go back to idle straight from the lookup state.
//   Flush walks the recency ranks one per cycle after the lookup state,
//   stalling only when a writeback order finds the result register still
//   occupied, and then loads the done item. The tag compare covers all
//   slots in parallel, and there is a single result register.
//   A result waits in the result register while rsp.ready is low; the next
//   request is still accepted, and the sequencer holds when it needs the
//   register again. arst_n clears valid, dirty and rank state at once, so
//   the directory is empty and requests are taken right after reset.
// ----------------------------------------------------------------------------
`include "lru_writeback_block_cache_directory_macros.svh"

module lru_writeback_block_cache_directory
	import lwbcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lwbcd_req_if.sink   req,
	lwbcd_rsp_if.source rsp
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_st;
	logic     in_ready;

	// Sequencer
	lwbcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.st       (dp_st),
		.cmd      (dp_cmd)
	);

	// Directory datapath
	lwbcd_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (dp_cmd),
		.st              (dp_st),
		.in_cmd          (req.cmd),
		.in_block_no     (req.block_no),
		.in_do_read      (req.do_read),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_kind        (rsp.kind),
		.out_block_addr  (rsp.block_addr),
		.out_slot        (rsp.slot),
		.out_hit         (rsp.hit),
		.out_fill_needed (rsp.fill_needed),
		.out_last        (rsp.last)
	);

	assign req.ready = in_ready;

	// Checks
	`LWBCD_ASSERT_NXT(a_one_at_a_time, clk, arst_n, req.valid && req.ready, !req.ready, "request accepted while busy")
	`LWBCD_ASSERT_NOW(a_wb_not_last, clk, arst_n, rsp.valid && rsp.kind == KIND_WB, !rsp.last && !rsp.hit && !rsp.fill_needed, "writeback order with last, hit or fill")
	`LWBCD_ASSERT_NOW(a_done_last, clk, arst_n, rsp.valid && rsp.kind == KIND_DONE, rsp.last && rsp.block_addr == '0, "flush done malformed")
	`LWBCD_ASSERT_NOW(a_hit_no_fill, clk, arst_n, rsp.valid && rsp.hit, rsp.kind == KIND_ANSWER && !rsp.fill_needed, "hit answer asks for fill")

endmodule
